[rtl/lsb_steg_extract_sentinel_unit_defines.svh]
// Assertion macros for the extractor
`ifndef LSB_STEG_EXTRACT_SENTINEL_UNIT_DEFINES_SVH
`define LSB_STEG_EXTRACT_SENTINEL_UNIT_DEFINES_SVH

// same-cycle implication
`define LSBX_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define LSBX_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/lsbx_pkg.sv]
`timescale 1ns / 1ps

package lsbx_pkg;

  localparam int OFFSET_BITS   = 24;
  localparam int INTERVAL_BITS = 16;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_MODE      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_OFFSET  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYTE_INTERVAL = 2'd2;

  localparam logic [2:0] SENTINEL_LEN = 3'd6;

  typedef struct packed {
    logic                     bit_mode;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [INTERVAL_BITS-1:0] byte_interval;
  } lsbx_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } lsbx_result_t;

  function automatic logic [7:0] sentinel_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd1:    b = 8'hFF;
      3'd4:    b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/lsbx_core.sv]
`timescale 1ns / 1ps

module lsbx_core import lsbx_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             data_in,
  input  lsbx_cfg_t              cfg,
  input  logic                   offset_load,
  input  logic [OFFSET_BITS-1:0] offset_value,
  output lsbx_result_t           result,
  output logic                   finished
);

  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] next_pick;
  logic [POSITION_BITS-1:0] next_pick_next;
  logic [POSITION_BITS-1:0] offset;
  logic [POSITION_BITS-1:0] step;
  logic [2:0]               bit_count;
  logic [2:0]               bit_count_next;
  logic [7:0]               assembly;
  logic [7:0]               assembly_next;
  logic [7:0]               shifted;
  logic [2:0]               match_step;
  logic [2:0]               match_step_next;
  logic [2:0]               step_inc;
  logic                     finished_next;
  logic                     emit;
  logic [7:0]               emit_byte;
  logic                     hit;
  logic                     last;

  always_comb begin
    offset   = POSITION_BITS'(cfg.start_offset);
    step     = (cfg.byte_interval == '0) ? POSITION_BITS'(1)
                                         : POSITION_BITS'(cfg.byte_interval);
    shifted  = {assembly[6:0], data_in[0]};
    position_next  = position + POSITION_BITS'(1);
    next_pick_next = next_pick;
    bit_count_next = bit_count;
    assembly_next  = assembly;
    emit      = 1'b0;
    emit_byte = data_in;
    if (cfg.bit_mode) begin
      if (position >= offset) begin
        bit_count_next = bit_count + 3'd1;
        assembly_next  = shifted;
        if (bit_count == 3'd7) begin
          emit          = 1'b1;
          emit_byte     = shifted;
          assembly_next = '0;
        end
      end
    end else begin
      if (position == next_pick) begin
        emit           = 1'b1;
        next_pick_next = next_pick + step;
      end
    end
    step_inc = match_step + 3'd1;
    hit  = (match_step < SENTINEL_LEN) && (emit_byte == sentinel_byte(match_step));
    last = emit && hit && (step_inc == SENTINEL_LEN);
    match_step_next = match_step;
    if (emit) begin
      match_step_next = hit ? step_inc : 3'd0;
    end
    finished_next = finished | last;
    result.valid = emit && !finished;
    result.data  = emit_byte;
    result.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      next_pick  <= '0;
      bit_count  <= '0;
      assembly   <= '0;
      match_step <= '0;
      finished   <= 1'b0;
    end else if (offset_load) begin
      next_pick <= POSITION_BITS'(offset_value);
    end else if (advance && !finished) begin
      position   <= position_next;
      next_pick  <= next_pick_next;
      bit_count  <= bit_count_next;
      assembly   <= assembly_next;
      match_step <= match_step_next;
      finished   <= finished_next;
    end
  end

endmodule

[rtl/lsb_steg_extract_sentinel_unit.sv]
`timescale 1ns / 1ps
// An accepted cover byte is held in the input register; a message byte it yields is
// held in the result register. Throughput: one cover byte per cycle while the output
// is not stalled; once the input register holds a byte, a waiting result stalls it.
// Reset (rst, synchronous): counters, matcher and handshake flags cleared,
// registers to bit mode, offset 0, interval 1.
`include "lsb_steg_extract_sentinel_unit_defines.svh"

module lsb_steg_extract_sentinel_unit import lsbx_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                cover_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                message_byte,
  output logic                      is_last,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  lsbx_cfg_t    cfg;
  lsbx_result_t result;
  logic         in_vld;
  logic [7:0]   in_byte;
  logic         advance;
  logic         offset_load;
  logic         finished;

  assign advance     = in_vld && !(out_valid && out_stall);
  assign in_stall    = in_vld && !advance;
  assign offset_load = cfg_we && (cfg_index == REG_START_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_mode      <= 1'b1;
      cfg.start_offset  <= '0;
      cfg.byte_interval <= INTERVAL_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_MODE:      cfg.bit_mode      <= cfg_data[0];
        REG_START_OFFSET:  cfg.start_offset  <= cfg_data[OFFSET_BITS-1:0];
        REG_BYTE_INTERVAL: cfg.byte_interval <= cfg_data[INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // hold the request until the core takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= cover_byte;
    end
  end

  lsbx_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .data_in      (in_byte),
    .cfg          (cfg),
    .offset_load  (offset_load),
    .offset_value (cfg_data[OFFSET_BITS-1:0]),
    .result       (result),
    .finished     (finished)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      message_byte <= result.data;
      is_last      <= result.last;
    end
  end

  `LSBX_ASSERT_NOW(a_last_sets_finished, out_valid && is_last, finished, "last without finish")
  `LSBX_ASSERT_NOW(a_last_is_zero, out_valid && is_last, message_byte == 8'h00, "bad sentinel end")
  `LSBX_ASSERT_NEXT(a_quiet_after_finish, finished && !out_valid, !out_valid, "output after finish")

endmodule
